/* rtl/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int CoordW = 6;
  localparam int DimW   = 7;
  localparam int AddrW  = 12;
  localparam int ColorW = 32;
  localparam int IdxW   = 2;
  localparam int ErrW   = 9;

  localparam logic [ColorW-1:0] ColorReset = 32'd255;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegCanvasWidth  = 2'd0;
  localparam logic [IdxW-1:0] RegCanvasHeight = 2'd1;
  localparam logic [IdxW-1:0] RegStrokeColor  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // latch a new line command
    logic emit;  // push the current pixel into the output register and step
  } lr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic at_end;    // current pixel equals the end point
  } lr_status_t;

endpackage

/* rtl/lr_ctrl.sv */
// ----------------------------------------------------------------------------
// lr_ctrl
// Line sequencer: waits for a command, then steps one pixel per free output
// slot until the end point has been emitted.
// ----------------------------------------------------------------------------
module lr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lr_pkg::lr_status_t status_i,
  output lr_pkg::lr_cmd_t    cmd_o
);
  import lr_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;

  // Decode commands from the current state
  always_comb begin
    in_ready_o = (state_q == StIdle);
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.emit = (state_q == StRun) && status_i.out_free;
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StRun;
      end
      StRun: begin
        if (status_i.out_free && status_i.at_end) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/lr_datapath.sv */
// ----------------------------------------------------------------------------
// lr_datapath
// Configuration registers, Bresenham error stepper and output register with
// address generation and canvas test.
// ----------------------------------------------------------------------------
module lr_datapath #(
  parameter int MAX_DIM = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_valid_i,
  input  logic [lr_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [lr_pkg::ColorW-1:0]  cfg_data_i,
  // line command
  input  logic [lr_pkg::CoordW-1:0]  start_x_i,
  input  logic [lr_pkg::CoordW-1:0]  start_y_i,
  input  logic [lr_pkg::CoordW-1:0]  end_x_i,
  input  logic [lr_pkg::CoordW-1:0]  end_y_i,
  // control
  input  lr_pkg::lr_cmd_t            cmd_i,
  output lr_pkg::lr_status_t         status_o,
  // result
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lr_pkg::CoordW-1:0]  pixel_x_o,
  output logic [lr_pkg::CoordW-1:0]  pixel_y_o,
  output logic [lr_pkg::AddrW-1:0]   pixel_address_o,
  output logic [lr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                       write_enable_o,
  output logic                       last_o
);
  import lr_pkg::*;

  localparam logic [CoordW-1:0] CoordMax = CoordW'(MAX_DIM - 1);
  localparam logic [DimW-1:0]   DimMax   = DimW'(MAX_DIM);

  logic [DimW-1:0]   width_q, height_q;
  logic [ColorW-1:0] color_q;
  logic [DimW-1:0]   cfg_dim;

  // Saturate canvas size writes to the maximum span
  assign cfg_dim = (cfg_data_i[DimW-1:0] > DimMax) ? DimMax : cfg_data_i[DimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimMax;
      height_q <= DimMax;
      color_q  <= ColorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCanvasWidth:  width_q  <= cfg_dim;
        RegCanvasHeight: height_q <= cfg_dim;
        RegStrokeColor:  color_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp command coordinates and set up deltas
  logic [CoordW-1:0] sx_c, sy_c, ex_c, ey_c;
  logic [CoordW-1:0] dx_in, dy_in;

  assign sx_c  = (start_x_i > CoordMax) ? CoordMax : start_x_i;
  assign sy_c  = (start_y_i > CoordMax) ? CoordMax : start_y_i;
  assign ex_c  = (end_x_i > CoordMax) ? CoordMax : end_x_i;
  assign ey_c  = (end_y_i > CoordMax) ? CoordMax : end_y_i;
  assign dx_in = (ex_c > sx_c) ? (ex_c - sx_c) : (sx_c - ex_c);
  assign dy_in = (ey_c > sy_c) ? (ey_c - sy_c) : (sy_c - ey_c);

  logic [CoordW-1:0]        x_q, y_q, xe_q, ye_q, dx_q, dy_q;
  logic                     sxp_q, syp_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [ErrW:0]     e2, dx_s, dy_neg;
  logic                     x_step, y_step;
  logic signed [ErrW-1:0]   err_next;

  // Bresenham step decision, both tests on the same doubled error
  assign e2       = {err_q, 1'b0};
  assign dx_s     = $signed({{(ErrW+1-CoordW){1'b0}}, dx_q});
  assign dy_neg   = -$signed({{(ErrW+1-CoordW){1'b0}}, dy_q});
  assign x_step   = (e2 > dy_neg);
  assign y_step   = (e2 < dx_s);
  assign err_next = err_q
                  - (x_step ? $signed({{(ErrW-CoordW){1'b0}}, dy_q}) : '0)
                  + (y_step ? $signed({{(ErrW-CoordW){1'b0}}, dx_q}) : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= sx_c;
      y_q   <= sy_c;
      xe_q  <= ex_c;
      ye_q  <= ey_c;
      dx_q  <= dx_in;
      dy_q  <= dy_in;
      sxp_q <= (sx_c < ex_c);
      syp_q <= (sy_c < ey_c);
      err_q <= $signed({{(ErrW-CoordW){1'b0}}, dx_in})
             - $signed({{(ErrW-CoordW){1'b0}}, dy_in});
    end else if (cmd_i.emit && !status_o.at_end) begin
      if (x_step) x_q <= sxp_q ? x_q + 1'b1 : x_q - 1'b1;
      if (y_step) y_q <= syp_q ? y_q + 1'b1 : y_q - 1'b1;
      err_q <= err_next;
    end
  end

  // Canvas test and framebuffer address of the current pixel
  logic                  in_canvas;
  logic [CoordW+DimW:0]  addr_full;

  assign in_canvas = ({1'b0, x_q} < width_q) && ({1'b0, y_q} < height_q);
  assign addr_full = (CoordW+DimW+1)'(y_q * width_q) + (CoordW+DimW+1)'(x_q);

  always_comb begin
    status_o.at_end   = (x_q == xe_q) && (y_q == ye_q);
    status_o.out_free = !out_valid_o || out_ready_i;
  end

  // Hold the output beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_x_o       <= x_q;
      pixel_y_o       <= y_q;
      pixel_address_o <= in_canvas ? addr_full[AddrW-1:0] : '0;
      pixel_color_o   <= color_q;
      write_enable_o  <= in_canvas;
      last_o          <= status_o.at_end;
    end
  end

endmodule

/* rtl/line_rasterizer.sv */
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line stepper: one line command in, one pixel beat per step out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes a line command with start and
//   end coordinates. Output channel (out_valid_o/out_ready_i) returns one beat
//   per pixel from start to end inclusive; last_o marks the end point.
//   write_enable_o is low, and pixel_address_o zero, for pixels outside the
//   configured canvas. The config channel (cfg_valid_i/cfg_ready_o) writes
//   canvas width, height and stroke color; it is always ready and should be
//   used only while no line is in flight.
// Timing:
//   A command is latched into the stepper registers when accepted; each pixel
//   is then pushed into the output register, one pixel per cycle when the
//   receiver never stalls, out of the single error-stepper register. The next
//   command is accepted once the last pixel has entered the output register.
// Reset and stall:
//   Reset returns to idle with a 64x64 canvas clamped to MAX_DIM and color
//   0x000000FF. A stall on out_ready_i freezes the stepper; no beat is lost.
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int MAX_DIM = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lr_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [lr_pkg::ColorW-1:0]  cfg_data_i,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lr_pkg::CoordW-1:0]  start_x_i,
  input  logic [lr_pkg::CoordW-1:0]  start_y_i,
  input  logic [lr_pkg::CoordW-1:0]  end_x_i,
  input  logic [lr_pkg::CoordW-1:0]  end_y_i,
  // pixel channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lr_pkg::CoordW-1:0]  pixel_x_o,
  output logic [lr_pkg::CoordW-1:0]  pixel_y_o,
  output logic [lr_pkg::AddrW-1:0]   pixel_address_o,
  output logic [lr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                       write_enable_o,
  output logic                       last_o
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  assign cfg_ready_o = 1'b1;

  lr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lr_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .write_enable_o  (write_enable_o),
    .last_o          (last_o)
  );

endmodule

/* tb/line_pixel_checker.sv */
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches the config, command and pixel channels of the line rasterizer.
// Predicts every pixel beat of each accepted line with its own Bresenham
// stepper and canvas registers. Compares each pixel beat field by field in
// order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_checker #(
  parameter int MAX_DIM = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [lr_pkg::IdxW-1:0]   cfg_index_i,
  input  logic [lr_pkg::ColorW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [lr_pkg::CoordW-1:0] start_x_i,
  input  logic [lr_pkg::CoordW-1:0] start_y_i,
  input  logic [lr_pkg::CoordW-1:0] end_x_i,
  input  logic [lr_pkg::CoordW-1:0] end_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [lr_pkg::CoordW-1:0] pixel_x_i,
  input  logic [lr_pkg::CoordW-1:0] pixel_y_i,
  input  logic [lr_pkg::AddrW-1:0]  pixel_address_i,
  input  logic [lr_pkg::ColorW-1:0] pixel_color_i,
  input  logic                      write_enable_i,
  input  logic                      last_i,
  output int                        error_count_o,
  output int                        pending_o
);
  import lr_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic              we;
    logic              last;
  } pixel_beat_t;

  pixel_beat_t       expected_pixels[$];
  logic [DimW-1:0]   canvas_w;
  logic [DimW-1:0]   canvas_h;
  logic [ColorW-1:0] stroke;

  assign pending_o = expected_pixels.size();

  // Saturate a written canvas size to the largest supported dimension
  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    return (v > MAX_DIM) ? DimW'(MAX_DIM) : v;
  endfunction

  // Step the line from start to end and queue one beat per pixel
  function automatic void queue_line_pixels(input int x0, input int y0,
                                            input int x1, input int y1);
    int          x;
    int          y;
    int          dx;
    int          dy;
    int          step_x;
    int          step_y;
    int          err;
    int          e2;
    int          count;
    bit          at_end;
    pixel_beat_t px;
    x      = x0;
    y      = y0;
    dx     = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy     = (y1 > y0) ? y1 - y0 : y0 - y1;
    step_x = (x0 < x1) ? 1 : -1;
    step_y = (y0 < y1) ? 1 : -1;
    err    = dx - dy;
    count  = 0;
    do begin
      at_end   = (x == x1) && (y == y1);
      px.x     = CoordW'(x);
      px.y     = CoordW'(y);
      px.we    = (x < canvas_w) && (y < canvas_h);
      px.addr  = px.we ? AddrW'(y * canvas_w + x) : '0;
      px.color = stroke;
      px.last  = at_end;
      expected_pixels.push_back(px);
      count++;
      if (!at_end) begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x   += step_x;
        end
        if (e2 < dx) begin
          err += dx;
          y   += step_y;
        end
      end
    end while (!at_end && count < MAX_DIM);
  endfunction

  function automatic void check_field(input string name, input logic [ColorW-1:0] exp_v,
                                      input logic [ColorW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count_o++;
    end
  endfunction

  // Track registers, queue predictions and compare pixel beats
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t exp_px;
    if (!rst_ni) begin
      canvas_w      = DimW'(MAX_DIM);
      canvas_h      = DimW'(MAX_DIM);
      stroke        = ColorReset;
      error_count_o = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegCanvasWidth:  canvas_w = sat_dim(cfg_data_i[DimW-1:0]);
          RegCanvasHeight: canvas_h = sat_dim(cfg_data_i[DimW-1:0]);
          RegStrokeColor:  stroke   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel beat at x=%0d y=%0d", pixel_x_i, pixel_y_i);
          error_count_o++;
        end else begin
          exp_px = expected_pixels.pop_front();
          check_field("pixel_x", exp_px.x, pixel_x_i);
          check_field("pixel_y", exp_px.y, pixel_y_i);
          check_field("pixel_address", exp_px.addr, pixel_address_i);
          check_field("pixel_color", exp_px.color, pixel_color_i);
          check_field("write_enable", exp_px.we, write_enable_i);
          check_field("last", exp_px.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        queue_line_pixels(start_x_i, start_y_i, end_x_i, end_y_i);
      end
    end
  end

endmodule

/* tb/line_rasterizer_tb.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// Drives line commands and canvas settings into the rasterizer under random
// sender and receiver idling. A side checker predicts and compares every
// pixel beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int MaxDim      = 64;
  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 7;
  localparam int BlockCount  = 8;
  localparam int BlockLines  = 18;
  localparam logic [IdxW-1:0] RegUnmapped = 2'd3;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IdxW-1:0]   cfg_index_i = '0;
  logic [ColorW-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CoordW-1:0] start_x_i   = '0;
  logic [CoordW-1:0] start_y_i   = '0;
  logic [CoordW-1:0] end_x_i     = '0;
  logic [CoordW-1:0] end_y_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoordW-1:0] pixel_x_o;
  logic [CoordW-1:0] pixel_y_o;
  logic [AddrW-1:0]  pixel_address_o;
  logic [ColorW-1:0] pixel_color_o;
  logic              write_enable_o;
  logic              last_o;

  int send_idle_pct = 14;
  int recv_idle_pct = 47;
  int error_count;
  int pending_pixels;

  line_rasterizer #(
    .MAX_DIM(MaxDim)
  ) u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_o, .out_ready_i, .pixel_x_o, .pixel_y_o, .pixel_address_o,
    .pixel_color_o, .write_enable_o, .last_o
  );

  line_pixel_checker #(
    .MAX_DIM(MaxDim)
  ) u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_x_i(pixel_x_o),
    .pixel_y_i(pixel_y_o), .pixel_address_i(pixel_address_o),
    .pixel_color_i(pixel_color_o), .write_enable_i(write_enable_o), .last_i(last_o),
    .error_count_o(error_count), .pending_o(pending_pixels)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Stall the pixel channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Hold one command beat until accepted, after a random idle gap
  task automatic send_line(input int sx, input int sy, input int ex, input int ey);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= CoordW'(sx);
    start_y_i  <= CoordW'(sy);
    end_x_i    <= CoordW'(ex);
    end_y_i    <= CoordW'(ey);
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_pixels != 0);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ColorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic release_cfg();
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Pick a canvas size: mostly in range, sometimes zero, one, full or oversized
  function automatic logic [ColorW-1:0] pick_dim_data();
    logic [ColorW-1:0] data;
    data = $urandom();
    case ($urandom_range(9, 0))
      0:       data[DimW-1:0] = '0;
      1:       data[DimW-1:0] = 7'd1;
      2:       data[DimW-1:0] = 7'd64;
      3:       data[DimW-1:0] = 7'($urandom_range(127, 65));
      default: data[DimW-1:0] = 7'($urandom_range(64, 1));
    endcase
    return data;
  endfunction

  task automatic apply_random_setup();
    logic [ColorW-1:0] color;
    case ($urandom_range(3, 0))
      0:       color = '0;
      1:       color = '1;
      default: color = $urandom();
    endcase
    write_reg(RegCanvasWidth, pick_dim_data());
    write_reg(RegCanvasHeight, pick_dim_data());
    write_reg(RegStrokeColor, color);
    if ($urandom_range(3, 0) == 0) begin
      write_reg(RegUnmapped, $urandom());
    end
    release_cfg();
  endtask

  function automatic int clip_coord(input int v);
    return (v < 0) ? 0 : (v > MaxDim - 1) ? MaxDim - 1 : v;
  endfunction

  // Mix long random lines, short lines and axis or diagonal lines
  task automatic send_random_line();
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    sx = $urandom_range(63, 0);
    sy = $urandom_range(63, 0);
    ex = $urandom_range(63, 0);
    ey = $urandom_range(63, 0);
    case ($urandom_range(3, 0))
      2: begin
        ex = clip_coord(sx + $urandom_range(10, 0) - 5);
        ey = clip_coord(sy + $urandom_range(10, 0) - 5);
      end
      3: begin
        len = $urandom_range(127, 0) - 63;
        case ($urandom_range(2, 0))
          0: ey = sy;
          1: ex = sx;
          default: begin
            ex = clip_coord(sx + len);
            ey = clip_coord(($urandom_range(1, 0) != 0) ? sy + (ex - sx) : sy - (ex - sx));
          end
        endcase
      end
      default: ;
    endcase
    send_line(sx, sy, ex, ey);
  endtask

  // Bound the run in case the block hangs
  initial begin
    #5_000_000;
    $display("line_rasterizer_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: degenerate, extremes, axes, diagonals and all octants
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(0, 0, 63, 63);
    send_line(63, 0, 0, 63);
    send_line(0, 0, 63, 0);
    send_line(0, 63, 0, 0);
    send_line(10, 10, 40, 20);
    send_line(40, 20, 10, 10);
    send_line(10, 10, 20, 40);
    send_line(20, 40, 10, 10);
    send_line(10, 20, 40, 10);
    send_line(40, 10, 10, 20);
    send_line(20, 10, 10, 40);
    send_line(10, 40, 20, 10);
    send_line(0, 0, 63, 1);
    send_line(63, 62, 0, 63);

    // Oversized width saturates, zero height masks every pixel
    drain();
    write_reg(RegCanvasWidth, 32'd100);
    write_reg(RegCanvasHeight, 32'd0);
    write_reg(RegStrokeColor, 32'd0);
    release_cfg();
    send_line(0, 0, 63, 63);
    send_line(5, 5, 5, 5);

    // Single-pixel canvas, full color, write to an unmapped index
    drain();
    write_reg(RegCanvasWidth, 32'd1);
    write_reg(RegCanvasHeight, 32'd1);
    write_reg(RegStrokeColor, 32'hFFFF_FFFF);
    write_reg(RegUnmapped, 32'h0000_0005);
    release_cfg();
    send_line(0, 0, 3, 3);
    send_line(1, 0, 0, 1);

    // Random: swap idling between the sides, then run without idling
    for (int blk = 0; blk < BlockCount; blk++) begin
      drain();
      if (blk >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (blk >= 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 14;
      end
      apply_random_setup();
      for (int i = 0; i < BlockLines; i++) begin
        send_random_line();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (error_count == 0 && pending_pixels == 0) begin
      $display("line_rasterizer_tb: done, clean");
    end else begin
      $display("line_rasterizer_tb: done, errors");
    end
    $finish;
  end

endmodule
